// ----- rtl/ias_pkg.sv -----
package ias_pkg;

  // Sequencer modes, also the code on the result's mode field
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_IDLE       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ARM_WAIT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ARMING     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ARMED      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRIP_DELAY = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ALARM      = 3'd5;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ARMING_SECONDS     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_DELAY_SECONDS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_SECONDS      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_AVAILABLE     = 8'd3;

  localparam int SEC_W   = 8;
  localparam int SEC_MAX = (1 << SEC_W) - 1;
  localparam logic [SEC_W-1:0] ARMING_SECONDS_RST     = 8'd20;
  localparam logic [SEC_W-1:0] TRIP_DELAY_SECONDS_RST = 8'd10;
  localparam logic [SEC_W-1:0] ALARM_SECONDS_RST      = 8'd60;
  localparam logic             LINK_AVAILABLE_RST     = 1'b1;

  localparam int TICKS_PER_SECOND_DEF   = 10;
  localparam int POLL_HOLD_SECONDS      = 5;
  localparam int ALARM_SLOTS_PER_SECOND = 5;
  localparam int MS_PER_SECOND          = 1000;
  localparam int BLINK_SLOT_MS          = 100;
  localparam int BLINK_SLOTS_PER_SECOND = MS_PER_SECOND / BLINK_SLOT_MS;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              status_led;
    logic              armed_led;
    logic              relay_on;
    logic              send_alert;
    logic              config_poll;
    logic [1:0]        trip_flags;
  } result_t;

endpackage

// ----- rtl/ias_if.sv -----
interface ias_in_if;
  logic valid;
  logic ready;
  logic key_closed;
  logic config_button;
  logic trip_one_active;
  logic trip_two_active;

  modport source (output valid, key_closed, config_button, trip_one_active,
                  trip_two_active, input ready);
  modport sink (input valid, key_closed, config_button, trip_one_active,
                trip_two_active, output ready);
endinterface

interface ias_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       status_led;
  logic       armed_led;
  logic       relay_on;
  logic       send_alert;
  logic       config_poll;
  logic [1:0] trip_flags;

  modport source (output valid, mode, status_led, armed_led, relay_on, send_alert,
                  config_poll, trip_flags, input ready);
  modport sink (input valid, mode, status_led, armed_led, relay_on, send_alert,
                config_poll, trip_flags, output ready);
endinterface

interface ias_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/intrusion_alarm_sequencer_top.sv -----
// Intrusion alarm sequencer. Each input word is one tick of 1/TICKS_PER_SECOND s
// carrying the key switch, the config button and the two trip channel levels, and
// yields exactly one result word (mode, LEDs, relay, alert and poll pulses, trip
// flags) describing the state after that tick. One tick is taken per clock cycle
// while the output buffer has room; the result is registered there, and the
// two-word buffer accepts one more tick while the sink stalls. Blink phases are
// tracked by small counters beside the tick counter, so no divider is needed.
// Configuration writes (arming, trip delay and alarm seconds, link available)
// are always accepted and must only be issued while the block is idle.
module intrusion_alarm_sequencer_top #(
  parameter int TICKS_PER_SECOND = ias_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ias_in_if.sink   in_ch,
  ias_out_if.source out_ch,
  ias_cfg_if.sink  cfg_ch
);
  import ias_pkg::*;

  localparam int TPS        = TICKS_PER_SECOND;
  localparam int CNT_W      = $clog2(SEC_MAX * TPS + 1);
  localparam int PH_W       = $clog2(TPS);
  localparam int RM_W       = $clog2(TPS + BLINK_SLOTS_PER_SECOND);
  localparam int ALARM_TRIM = (TPS + ALARM_SLOTS_PER_SECOND - 1) / ALARM_SLOTS_PER_SECOND;

  localparam logic [CNT_W:0]  TPS_CNT  = (CNT_W+1)'(TPS);
  localparam logic [CNT_W:0]  POLL_LIM = (CNT_W+1)'(POLL_HOLD_SECONDS * TPS);
  localparam logic [PH_W:0]   TPS_PH   = (PH_W+1)'(TPS);
  localparam logic [PH_W-1:0] HALF_PH  = PH_W'(TPS / 2);
  localparam logic [RM_W:0]   TPS_RM   = (RM_W+1)'(TPS);
  localparam logic [RM_W:0]   TPS2_RM  = (RM_W+1)'(2 * TPS);
  localparam logic [RM_W:0]   STEP_RM  = (RM_W+1)'(BLINK_SLOTS_PER_SECOND);

  // configuration registers
  logic [SEC_W-1:0] arming_r, trip_delay_r, alarm_r;
  logic             link_r;

  // sequencer state
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CNT_W-1:0]  tick_r, tick_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;   // tick_r mod TPS
  logic [RM_W-1:0]   brem_r, brem_nxt;     // (tick_r*10) mod TPS, alarm blink
  logic              bodd_r, bodd_nxt;     // parity of tick_r*10/TPS
  logic [1:0]        trips_r, trips_nxt;
  logic [1:0]        prev_r;
  logic              relay_r, relay_nxt;
  logic              poll_busy_r, poll_busy_nxt;

  logic [1:0]       levels, changed, trips_upd;
  logic [CNT_W:0]   tick_inc_v;
  logic             tick_inc;
  logic [CNT_W:0]   arm_lim, trip_lim;
  logic [CNT_W-1:0] alarm_lim;
  logic [PH_W:0]    phase_inc;
  logic [RM_W:0]    brem_sum;
  logic             alert, poll, status, armed;
  logic             accept;
  result_t          res;

  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arming_r     <= ARMING_SECONDS_RST;
      trip_delay_r <= TRIP_DELAY_SECONDS_RST;
      alarm_r      <= ALARM_SECONDS_RST;
      link_r       <= LINK_AVAILABLE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ARMING_SECONDS:     arming_r     <= cfg_ch.data;
        CFG_TRIP_DELAY_SECONDS: trip_delay_r <= cfg_ch.data;
        CFG_ALARM_SECONDS:      alarm_r      <= cfg_ch.data;
        CFG_LINK_AVAILABLE:     link_r       <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign levels     = {in_ch.trip_two_active, in_ch.trip_one_active};
  assign changed    = levels ^ prev_r;
  assign trips_upd  = (trips_r & ~changed) | (levels & changed);
  assign tick_inc_v = {1'b0, tick_r} + (CNT_W+1)'(1);
  assign arm_lim    = (CNT_W+1)'(arming_r * TPS);
  assign trip_lim   = (CNT_W+1)'(trip_delay_r * TPS);
  // (5s-1)*TPS/5 rewritten as s*TPS - ceil(TPS/5)
  assign alarm_lim  = (alarm_r == '0) ? '0 : CNT_W'(alarm_r * TPS - ALARM_TRIM);

  always_comb begin
    mode_nxt      = mode_r;
    tick_nxt      = tick_r;
    tick_inc      = 1'b0;
    relay_nxt     = relay_r;
    poll_busy_nxt = poll_busy_r;
    trips_nxt     = trips_upd;
    alert         = 1'b0;
    poll          = 1'b0;
    case (mode_r)
      MODE_IDLE: begin
        relay_nxt = 1'b0;
        if (poll_busy_r) begin
          if (tick_inc_v >= POLL_LIM) begin
            poll_busy_nxt = 1'b0;
            tick_nxt      = '0;
          end else begin
            tick_inc = 1'b1;
          end
        end else if (in_ch.config_button) begin
          poll_busy_nxt = 1'b1;
          tick_nxt      = '0;
          poll          = 1'b1;
        end else if (in_ch.key_closed) begin
          mode_nxt = MODE_ARM_WAIT;
          tick_nxt = '0;
        end else if (tick_inc_v >= TPS_CNT) begin
          tick_nxt = '0;
        end else begin
          tick_inc = 1'b1;
        end
      end
      MODE_ARM_WAIT: begin
        if (tick_inc_v >= TPS_CNT) begin
          mode_nxt = MODE_ARMING;
          tick_nxt = '0;
        end else begin
          tick_inc = 1'b1;
        end
      end
      MODE_ARMING: begin
        if (!in_ch.key_closed) begin
          mode_nxt      = MODE_IDLE;
          tick_nxt      = '0;
          poll_busy_nxt = 1'b0;
          relay_nxt     = 1'b0;
        end else if (tick_inc_v >= arm_lim) begin
          mode_nxt  = MODE_ARMED;
          tick_nxt  = '0;
          trips_nxt = '0;
          relay_nxt = 1'b0;
        end else begin
          tick_inc = 1'b1;
        end
      end
      MODE_ARMED: begin
        relay_nxt = 1'b0;
        if (!in_ch.key_closed) begin
          mode_nxt      = MODE_IDLE;
          tick_nxt      = '0;
          poll_busy_nxt = 1'b0;
        end else if (trips_upd != 2'b00) begin
          mode_nxt = MODE_TRIP_DELAY;
          tick_nxt = '0;
        end
      end
      MODE_TRIP_DELAY: begin
        if (!in_ch.key_closed) begin
          mode_nxt      = MODE_IDLE;
          tick_nxt      = '0;
          poll_busy_nxt = 1'b0;
          relay_nxt     = 1'b0;
        end else if (tick_inc_v >= trip_lim) begin
          mode_nxt  = MODE_ALARM;
          tick_nxt  = '0;
          relay_nxt = 1'b1;
          alert     = link_r;
        end else begin
          tick_inc = 1'b1;
        end
      end
      MODE_ALARM: begin
        // time-up check wins over the key
        if (tick_r >= alarm_lim) begin
          mode_nxt = MODE_ARMING;
          tick_nxt = '0;
        end else if (!in_ch.key_closed) begin
          mode_nxt      = MODE_IDLE;
          tick_nxt      = '0;
          poll_busy_nxt = 1'b0;
          relay_nxt     = 1'b0;
        end else begin
          tick_inc = 1'b1;
        end
      end
      default: begin
        mode_nxt      = MODE_IDLE;
        tick_nxt      = '0;
        poll_busy_nxt = 1'b0;
        relay_nxt     = 1'b0;
      end
    endcase
    if (tick_inc) begin
      tick_nxt = tick_inc_v[CNT_W-1:0];
    end
  end

  // phase counters follow the tick counter: advance with it, clear with it
  assign phase_inc = {1'b0, phase_r} + (PH_W+1)'(1);
  assign brem_sum  = {1'b0, brem_r} + STEP_RM;

  always_comb begin
    phase_nxt = '0;
    brem_nxt  = '0;
    bodd_nxt  = 1'b0;
    if (tick_inc) begin
      phase_nxt = (phase_inc >= TPS_PH) ? '0 : phase_inc[PH_W-1:0];
      if (brem_sum >= TPS2_RM) begin
        brem_nxt = RM_W'(brem_sum - TPS2_RM);
        bodd_nxt = bodd_r;
      end else if (brem_sum >= TPS_RM) begin
        brem_nxt = RM_W'(brem_sum - TPS_RM);
        bodd_nxt = ~bodd_r;
      end else begin
        brem_nxt = brem_sum[RM_W-1:0];
        bodd_nxt = bodd_r;
      end
    end
  end

  always_comb begin
    status = 1'b0;
    armed  = 1'b0;
    case (mode_nxt)
      MODE_IDLE: begin
        if (poll_busy_nxt) begin
          status = 1'b0;
        end else if (trips_nxt != 2'b00) begin
          status = (phase_nxt >= HALF_PH);
        end else begin
          status = 1'b1;
        end
      end
      MODE_ARM_WAIT: begin
        status = 1'b1;
      end
      MODE_ARMING: begin
        status = 1'b1;
        armed  = (phase_nxt >= HALF_PH);
      end
      MODE_ARMED: begin
        armed = 1'b1;
      end
      MODE_TRIP_DELAY: begin
        status = 1'b1;
        armed  = 1'b1;
      end
      default: begin
        status = ~bodd_nxt;
        armed  = bodd_nxt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      tick_r      <= '0;
      phase_r     <= '0;
      brem_r      <= '0;
      bodd_r      <= 1'b0;
      trips_r     <= 2'b00;
      prev_r      <= 2'b00;
      relay_r     <= 1'b0;
      poll_busy_r <= 1'b0;
    end else if (accept) begin
      mode_r      <= mode_nxt;
      tick_r      <= tick_nxt;
      phase_r     <= phase_nxt;
      brem_r      <= brem_nxt;
      bodd_r      <= bodd_nxt;
      trips_r     <= trips_nxt;
      prev_r      <= levels;
      relay_r     <= relay_nxt;
      poll_busy_r <= poll_busy_nxt;
    end
  end

  always_comb begin
    res.mode        = mode_nxt;
    res.status_led  = status;
    res.armed_led   = armed;
    res.relay_on    = relay_nxt;
    res.send_alert  = alert;
    res.config_poll = poll;
    res.trip_flags  = trips_nxt;
  end

  result_t out_word;

  ias_out_skid u_out_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .push_ready (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_word)
  );

  assign out_ch.mode        = out_word.mode;
  assign out_ch.status_led  = out_word.status_led;
  assign out_ch.armed_led   = out_word.armed_led;
  assign out_ch.relay_on    = out_word.relay_on;
  assign out_ch.send_alert  = out_word.send_alert;
  assign out_ch.config_poll = out_word.config_poll;
  assign out_ch.trip_flags  = out_word.trip_flags;

  a_poll_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    poll_busy_r |-> mode_r == MODE_IDLE)
    else $error("config poll hold outside idle");

  a_armed_relay_off: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_ARMED |-> !relay_r)
    else $error("relay on while armed");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, phase_r} < TPS_PH) && ({1'b0, brem_r} < TPS_RM))
    else $error("phase counter out of range");

  a_armed_exits: assert property (@(posedge clk) disable iff (!rst_n)
    accept && mode_r == MODE_ARMED |=>
      mode_r == MODE_IDLE || mode_r == MODE_ARMED || mode_r == MODE_TRIP_DELAY)
    else $error("illegal exit from armed");

  a_alarm_entry: assert property (@(posedge clk) disable iff (!rst_n)
    accept && mode_r == MODE_TRIP_DELAY && mode_nxt == MODE_ALARM |=>
      relay_r && tick_r == '0)
    else $error("alarm entry without relay or counter clear");

endmodule

// ----- rtl/ias_out_skid.sv -----
module ias_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ias_pkg::result_t push_data,
  output logic             push_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ias_pkg::result_t out_data
);
  import ias_pkg::*;

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop        = main_valid_r & out_ready;
  assign push_ready = ~skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word held with empty output register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r && !out_ready |=> main_valid_r && $stable(main_r))
    else $error("stalled result word changed");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !pop |=> skid_valid_r && $stable(skid_r))
    else $error("skid word lost");

endmodule
